// File: rtl/core/sbi_pkg.sv
// shared constants, widths, stage numbers and types of the band-pass integrator
// no dependencies
package sbi_pkg;

	localparam int MAX_BINS  = 4096;
	localparam int BIN_W     = 12;
	localparam int CFG_BIN_W = 13;
	localparam int SMP_W     = 16;
	localparam int MAG_W     = 16;
	localparam int W_W       = 32;
	localparam int A_W       = MAG_W + W_W;
	localparam int P_W       = 2 * W_W;
	localparam int N_W       = A_W + W_W;
	localparam int D_W       = 2 * BIN_W + W_W;
	localparam int DIV_BITS  = 17;
	localparam int MAGO_W    = DIV_BITS + 1;
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 40;

	// pipeline stage numbers
	localparam int ST_FRONT = 1;
	localparam int ST_MUL   = 2;
	localparam int ST_PP    = 3;
	localparam int ST_N     = 4;
	localparam int ST_CHK   = 5;
	localparam int ST_DIV0  = 6;
	localparam int ST_RND   = ST_DIV0 + DIV_BITS;
	localparam int ST_OUT   = ST_RND + 1;

	// configuration register indexes
	localparam logic [1:0] REG_LOW_BIN   = 2'd0;
	localparam logic [1:0] REG_HIGH_BIN  = 2'd1;
	localparam logic [1:0] REG_TWICE     = 2'd2;
	localparam logic [1:0] REG_INV_OMEGA = 2'd3;

	// per-item control that travels beside the lanes
	typedef struct packed {
		logic band;
		logic neg_r;
		logic neg_i;
	} side_t;

endpackage

// File: rtl/core/spectrum_bandpass_integrate.sv
// top level of the spectrum band-pass integrator: config registers, front stage,
// two lanes (real and imaginary result) and the merge stage
// depends on sbi_pkg, sbi_lane, sbi_merge

// Takes one complex FFT bin per request and returns one q15 result per request,
// one every clock cycle when both sides keep up. The path holds 24 register stages:
// one front stage (band test, operand swap, divisor i or i*i), three multiplier
// stages (mag*W, then the second W as 32x32 and 16x32 partial products, then their
// sum), one range check, seventeen restoring-divider stages (one quotient bit
// each), one rounding stage and the output register.
// Both result parts are computed by two identical lanes side by side; the merge
// stage applies sign, saturation and the clip flag. Stalls collapse bubbles, so
// the input keeps taking requests while a result waits, until the pipe is full.
// Configuration: write only while the block holds no request in flight.
module spectrum_bandpass_integrate (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [31:0]                     cfg_data,
	// bin in: [11:0] bin_index, [27:12] real_in, [43:28] imag_in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sbi_pkg::IN_DATA_W-1:0]   s_tdata,
	// result out: [15:0] real_out, [31:16] imag_out, [32] clipped
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sbi_pkg::OUT_DATA_W-1:0]  m_tdata
);

	// configuration registers
	logic [sbi_pkg::CFG_BIN_W-1:0] low_bin_q, high_bin_q;
	logic                          twice_q;
	logic [sbi_pkg::W_W-1:0]       inv_omega_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bin_q   <= 13'd1;
			high_bin_q  <= 13'd4096;
			twice_q     <= 1'b0;
			inv_omega_q <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbi_pkg::REG_LOW_BIN:   low_bin_q   <= cfg_data[sbi_pkg::CFG_BIN_W-1:0];
				sbi_pkg::REG_HIGH_BIN:  high_bin_q  <= cfg_data[sbi_pkg::CFG_BIN_W-1:0];
				sbi_pkg::REG_TWICE:     twice_q     <= cfg_data[0];
				sbi_pkg::REG_INV_OMEGA: inv_omega_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and bubble-collapsing ready chain
	logic [sbi_pkg::ST_RND:sbi_pkg::ST_FRONT] vld_q;
	logic [sbi_pkg::ST_OUT:sbi_pkg::ST_FRONT] rdy;

	always_comb begin
		rdy[sbi_pkg::ST_OUT] = !m_tvalid || m_tready;
		for (int k = sbi_pkg::ST_RND; k >= sbi_pkg::ST_FRONT; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[sbi_pkg::ST_FRONT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[sbi_pkg::ST_FRONT]) begin
				vld_q[sbi_pkg::ST_FRONT] <= s_tvalid;
			end
			for (int k = sbi_pkg::ST_FRONT + 1; k <= sbi_pkg::ST_RND; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// front stage: band test, operand selection per integration mode
	logic [sbi_pkg::BIN_W-1:0]       bin;
	logic signed [sbi_pkg::SMP_W-1:0] re, im;
	logic [sbi_pkg::MAG_W-1:0]       abs_re, abs_im;
	logic [sbi_pkg::CFG_BIN_W-1:0]   lo_b, hi_b;
	logic                            in_band;

	assign bin    = s_tdata[11:0];
	assign re     = s_tdata[27:12];
	assign im     = s_tdata[43:28];
	assign abs_re = re[sbi_pkg::SMP_W-1] ? sbi_pkg::MAG_W'(-re) : sbi_pkg::MAG_W'(re);
	assign abs_im = im[sbi_pkg::SMP_W-1] ? sbi_pkg::MAG_W'(-im) : sbi_pkg::MAG_W'(im);
	// bin zero never passes, so the divisor is never zero in band
	assign lo_b   = (low_bin_q == '0) ? sbi_pkg::CFG_BIN_W'(1) : low_bin_q;
	assign hi_b   = (high_bin_q < sbi_pkg::CFG_BIN_W'(sbi_pkg::MAX_BINS)) ? high_bin_q
	              : sbi_pkg::CFG_BIN_W'(sbi_pkg::MAX_BINS);
	assign in_band = (sbi_pkg::CFG_BIN_W'(bin) >= lo_b) && (sbi_pkg::CFG_BIN_W'(bin) < hi_b);

	logic [sbi_pkg::MAG_W-1:0] mag_r_s1, mag_i_s1;
	logic [sbi_pkg::D_W-1:0]   d_s1;
	logic                      tw_s1;
	sbi_pkg::side_t            side_s [sbi_pkg::ST_FRONT:sbi_pkg::ST_RND];

	always_ff @(posedge clk) begin
		if (rdy[sbi_pkg::ST_FRONT]) begin
			tw_s1 <= twice_q;
			side_s[sbi_pkg::ST_FRONT].band <= in_band;
			if (twice_q) begin
				// -x * W^2 / (i^2 * 2^32)
				mag_r_s1 <= abs_re;
				mag_i_s1 <= abs_im;
				side_s[sbi_pkg::ST_FRONT].neg_r <= !re[sbi_pkg::SMP_W-1] && re != '0;
				side_s[sbi_pkg::ST_FRONT].neg_i <= !im[sbi_pkg::SMP_W-1] && im != '0;
				d_s1 <= sbi_pkg::D_W'(sbi_pkg::D_W'(bin) * sbi_pkg::D_W'(bin)) << sbi_pkg::W_W;
			end else begin
				// real from imag, imag from minus real, over i * 2^16
				mag_r_s1 <= abs_im;
				mag_i_s1 <= abs_re;
				side_s[sbi_pkg::ST_FRONT].neg_r <= im[sbi_pkg::SMP_W-1];
				side_s[sbi_pkg::ST_FRONT].neg_i <= !re[sbi_pkg::SMP_W-1] && re != '0;
				d_s1 <= sbi_pkg::D_W'(bin) << 16;
			end
		end
		for (int k = sbi_pkg::ST_FRONT + 1; k <= sbi_pkg::ST_RND; k++) begin
			if (rdy[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// the two lanes
	logic [sbi_pkg::MAGO_W-1:0] mag_r_out, mag_i_out;

	sbi_lane u_lane_re (
		.clk     (clk),
		.en      (rdy[sbi_pkg::ST_RND:sbi_pkg::ST_MUL]),
		.mag     (mag_r_s1),
		.d       (d_s1),
		.twice   (tw_s1),
		.w       (inv_omega_q),
		.mag_out (mag_r_out)
	);

	sbi_lane u_lane_im (
		.clk     (clk),
		.en      (rdy[sbi_pkg::ST_RND:sbi_pkg::ST_MUL]),
		.mag     (mag_i_s1),
		.d       (d_s1),
		.twice   (tw_s1),
		.w       (inv_omega_q),
		.mag_out (mag_i_out)
	);

	// merge and output register
	sbi_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (rdy[sbi_pkg::ST_OUT]),
		.in_valid  (vld_q[sbi_pkg::ST_RND]),
		.side      (side_s[sbi_pkg::ST_RND]),
		.mag_r     (mag_r_out),
		.mag_i     (mag_i_out),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

`ifndef SYNTHESIS
	// with the output register free, every stage can move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input stalled with empty output");

	// a clipped result has at least one part at a q15 limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> (m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 ||
			m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000))
		else $error("clip flag without saturated part");

	// an accepted request occupies the front stage next cycle
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[sbi_pkg::ST_FRONT]) else $error("request lost at entry");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:33] == 7'd0) else $error("nonzero padding");
`endif

endmodule

// File: rtl/core/sbi_lane.sv
// one lane: rounded magnitude of mag * w [* w] / d through a pipelined divider
// depends on sbi_pkg
module sbi_lane (
	input  logic                        clk,
	input  logic [sbi_pkg::ST_RND:sbi_pkg::ST_MUL] en,
	input  logic [sbi_pkg::MAG_W-1:0]   mag,
	input  logic [sbi_pkg::D_W-1:0]     d,
	input  logic                        twice,
	input  logic [sbi_pkg::W_W-1:0]     w,
	output logic [sbi_pkg::MAGO_W-1:0]  mag_out
);

	logic [sbi_pkg::A_W-1:0] a_s2, a_s3;
	logic [sbi_pkg::D_W-1:0] d_s2, d_s3, d_s4;
	logic                    tw_s2, tw_s3;
	logic [sbi_pkg::P_W-1:0] plo_s3;
	logic [sbi_pkg::A_W-1:0] phi_s3;
	logic [sbi_pkg::N_W-1:0] n_s4;

	logic [sbi_pkg::N_W-1:0]      rem_s [0:sbi_pkg::DIV_BITS];
	logic [sbi_pkg::DIV_BITS-1:0] quo_s [0:sbi_pkg::DIV_BITS];
	logic [sbi_pkg::D_W-1:0]      dv_s  [0:sbi_pkg::DIV_BITS];
	logic                         ovf_s [0:sbi_pkg::DIV_BITS];

	logic                         rnd_up;
	logic [sbi_pkg::MAGO_W-1:0]   mag_s;

	// product stages: 16x32, then the second factor split into 32x32 and 16x32
	always_ff @(posedge clk) begin
		if (en[sbi_pkg::ST_MUL]) begin
			a_s2  <= sbi_pkg::A_W'(mag) * sbi_pkg::A_W'(w);
			d_s2  <= d;
			tw_s2 <= twice;
		end
		if (en[sbi_pkg::ST_PP]) begin
			plo_s3 <= sbi_pkg::P_W'(a_s2[sbi_pkg::W_W-1:0]) * sbi_pkg::P_W'(w);
			phi_s3 <= sbi_pkg::A_W'(a_s2[sbi_pkg::A_W-1:sbi_pkg::W_W]) * sbi_pkg::A_W'(w);
			a_s3   <= a_s2;
			d_s3   <= d_s2;
			tw_s3  <= tw_s2;
		end
		if (en[sbi_pkg::ST_N]) begin
			n_s4 <= tw_s3 ? sbi_pkg::N_W'(plo_s3) + (sbi_pkg::N_W'(phi_s3) << sbi_pkg::W_W)
			              : sbi_pkg::N_W'(a_s3);
			d_s4 <= d_s3;
		end
		// quotient beyond the divider range saturates anyway
		if (en[sbi_pkg::ST_CHK]) begin
			ovf_s[0] <= n_s4 >= (sbi_pkg::N_W'(d_s4) << sbi_pkg::DIV_BITS);
			rem_s[0] <= n_s4;
			quo_s[0] <= '0;
			dv_s[0]  <= d_s4;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < sbi_pkg::DIV_BITS; k++) begin : g_div
		localparam int B = sbi_pkg::DIV_BITS - 1 - k;
		logic [sbi_pkg::N_W-1:0] dsh;
		assign dsh = sbi_pkg::N_W'(dv_s[k]) << B;
		always_ff @(posedge clk) begin
			if (en[sbi_pkg::ST_DIV0 + k]) begin
				if (rem_s[k] >= dsh) begin
					rem_s[k+1] <= rem_s[k] - dsh;
					quo_s[k+1] <= quo_s[k] | (sbi_pkg::DIV_BITS'(1) << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= quo_s[k];
				end
				dv_s[k+1]  <= dv_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// round to nearest, ties up on the magnitude
	assign rnd_up = ((sbi_pkg::D_W+1)'(rem_s[sbi_pkg::DIV_BITS][sbi_pkg::D_W-1:0]) << 1)
	                >= (sbi_pkg::D_W+1)'(dv_s[sbi_pkg::DIV_BITS]);

	always_ff @(posedge clk) begin
		if (en[sbi_pkg::ST_RND]) begin
			mag_s <= ovf_s[sbi_pkg::DIV_BITS] ? '1
			       : sbi_pkg::MAGO_W'(quo_s[sbi_pkg::DIV_BITS]) + sbi_pkg::MAGO_W'(rnd_up);
		end
	end

	assign mag_out = mag_s;

endmodule

// File: rtl/core/sbi_merge.sv
// merge stage: sign, q15 saturation, clip flag and the output register
// depends on sbi_pkg
module sbi_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  sbi_pkg::side_t                side,
	input  logic [sbi_pkg::MAGO_W-1:0]    mag_r,
	input  logic [sbi_pkg::MAGO_W-1:0]    mag_i,
	output logic                          out_valid,
	output logic [sbi_pkg::OUT_DATA_W-1:0] out_data
);

	logic [sbi_pkg::SMP_W-1:0] re_v, im_v;
	logic                      clip_r, clip_i;
	logic                      vld_q;
	logic [sbi_pkg::SMP_W-1:0] re_q, im_q;
	logic                      clip_q;

	function automatic logic [sbi_pkg::SMP_W:0] sat_q15(
		input logic [sbi_pkg::MAGO_W-1:0] m,
		input logic                       neg
	);
		logic [sbi_pkg::SMP_W-1:0] v;
		logic                      c;
		c = 1'b0;
		if (neg && m != '0) begin
			if (m > sbi_pkg::MAGO_W'(32768)) begin
				c = 1'b1;
				v = 16'h8000;
			end else begin
				v = sbi_pkg::SMP_W'(~m + 1'b1);
			end
		end else begin
			if (m > sbi_pkg::MAGO_W'(32767)) begin
				c = 1'b1;
				v = 16'h7fff;
			end else begin
				v = sbi_pkg::SMP_W'(m);
			end
		end
		return {c, v};
	endfunction

	always_comb begin
		{clip_r, re_v} = sat_q15(mag_r, side.neg_r);
		{clip_i, im_v} = sat_q15(mag_i, side.neg_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	// out-of-band bins leave as zero with no clip
	always_ff @(posedge clk) begin
		if (en) begin
			re_q   <= side.band ? re_v : '0;
			im_q   <= side.band ? im_v : '0;
			clip_q <= side.band && (clip_r || clip_i);
		end
	end

	assign out_valid = vld_q;
	assign out_data  = {7'd0, clip_q, im_q, re_q};

endmodule
